FILE: rtl/core/implicit_list_heap_allocator_core_assert.svh
// Assertion macros used by the heap allocator sequencer
`ifndef IMPLICIT_LIST_HEAP_ALLOCATOR_CORE_ASSERT_SVH
`define IMPLICIT_LIST_HEAP_ALLOCATOR_CORE_ASSERT_SVH

// Same-cycle implication, checked outside reset
`define HLA_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("heap allocator assertion failed");

// Next-cycle implication, checked outside reset
`define HLA_ASSERT_NEXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("heap allocator assertion failed");

`endif

FILE: rtl/core/hla_pkg.sv
// Shared constants and types of the heap allocator
package hla_pkg;

    localparam int unsigned HEAP_BYTES = 1048576;
    localparam int unsigned HEAP_WORDS = HEAP_BYTES / 4;
    localparam int WA   = $clog2(HEAP_WORDS);
    localparam int BW   = $clog2(HEAP_BYTES) + 1;
    localparam int DW   = 32;
    localparam int XW   = 33;
    localparam int REQW = 21;
    localparam int OFFW = 20;
    localparam int CHW  = 21;
    localparam int AZW  = 22;
    localparam int GZW  = 23;
    localparam int SUMW = ((BW > GZW) ? BW : GZW) + 1;
    localparam int STW  = 2;

    localparam logic [STW-1:0] ST_DONE = 2'd0;
    localparam logic [STW-1:0] ST_OOM  = 2'd1;
    localparam logic [STW-1:0] ST_NULL = 2'd2;

    localparam logic MODE_ALLOC = 1'b0;
    localparam logic MODE_FREE  = 1'b1;

    localparam logic [CHW-1:0] CHUNK_RESET = 21'd4096;

    typedef struct packed {
        logic          we;
        logic [WA-1:0] addr;
        logic [DW-1:0] wdata;
    } t_mem_req;

    typedef struct packed {
        logic [OFFW-1:0] offset;
        logic [STW-1:0]  status;
    } t_result;

    typedef struct packed {
        logic          sub;
        logic [XW-1:0] a;
        logic [XW-1:0] b;
        logic [XW-1:0] k;
    } t_alu_op;

endpackage

FILE: rtl/core/hla_ram.sv
// Single-port heap word memory with registered read data
module hla_ram import hla_pkg::*; (
    input  logic          i_clk,
    input  t_mem_req      i_req,
    output logic [DW-1:0] o_rdata
);

    logic [DW-1:0] r_mem [HEAP_WORDS];

    // Write on request, read the addressed word every cycle
    always_ff @(posedge i_clk) begin
        if (i_req.we) begin
            r_mem[i_req.addr] <= i_req.wdata;
        end
        o_rdata <= r_mem[i_req.addr];
    end

endmodule

FILE: rtl/core/hla_alu.sv
// Shared address and size adder: y = a +/- b + k
module hla_alu import hla_pkg::*; (
    input  t_alu_op       i_op,
    output logic [XW-1:0] o_y
);

    // Add or subtract, then apply the offset term
    assign o_y = i_op.sub ? (i_op.a - i_op.b + i_op.k) : (i_op.a + i_op.b + i_op.k);

endmodule

FILE: rtl/core/hla_ctrl.sv
// Sequencer for heap clear, init, first-fit search, growth, split and merge
`include "implicit_list_heap_allocator_core_assert.svh"
module hla_ctrl import hla_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_in_valid,
    output logic            o_in_ready,
    input  logic            i_mode,
    input  logic [REQW-1:0] i_req,
    input  logic [OFFW-1:0] i_off,
    input  logic [CHW-1:0]  i_chunk,
    output logic            o_res_valid,
    input  logic            i_res_ready,
    output t_result         o_res,
    output t_alu_op         o_alu_op,
    input  logic [XW-1:0]   i_alu_y,
    output t_mem_req        o_mem_req,
    input  logic [DW-1:0]   i_mem_rdata
);

    localparam int NS = 43;

    typedef enum logic [NS-1:0] {
        S_CLR  = NS'(1) << 0,  S_I0  = NS'(1) << 1,  S_I1  = NS'(1) << 2,
        S_I2   = NS'(1) << 3,  S_IDLE = NS'(1) << 4, S_SC0 = NS'(1) << 5,
        S_SC1  = NS'(1) << 6,  S_G0  = NS'(1) << 7,  S_G1  = NS'(1) << 8,
        S_G2   = NS'(1) << 9,  S_F0  = NS'(1) << 10, S_F1  = NS'(1) << 11,
        S_F2   = NS'(1) << 12, S_M0  = NS'(1) << 13, S_M1  = NS'(1) << 14,
        S_M2   = NS'(1) << 15, S_M3  = NS'(1) << 16, S_M4  = NS'(1) << 17,
        S_M5   = NS'(1) << 18, S_M6  = NS'(1) << 19, S_M7  = NS'(1) << 20,
        S_M8   = NS'(1) << 21, S_MA0 = NS'(1) << 22, S_MA1 = NS'(1) << 23,
        S_MB0  = NS'(1) << 24, S_MX0 = NS'(1) << 25, S_MX1 = NS'(1) << 26,
        S_MC0  = NS'(1) << 27, S_MC1 = NS'(1) << 28, S_MC2 = NS'(1) << 29,
        S_MC3  = NS'(1) << 30, S_MC4 = NS'(1) << 31, S_MY0 = NS'(1) << 32,
        S_MY1  = NS'(1) << 33, S_MEND = NS'(1) << 34, S_P0 = NS'(1) << 35,
        S_P1   = NS'(1) << 36, S_P2  = NS'(1) << 37, S_P3  = NS'(1) << 38,
        S_P4   = NS'(1) << 39, S_P5  = NS'(1) << 40, S_PN  = NS'(1) << 41,
        S_DONE = NS'(1) << 42
    } t_state;

    typedef enum logic [1:0] {
        CTX_INIT  = 2'd0,
        CTX_ALLOC = 2'd1,
        CTX_FREE  = 2'd2
    } t_ctx;

    localparam logic [XW-1:0] K_M4 = XW'(-4);
    localparam logic [XW-1:0] K_M8 = XW'(-8);
    localparam logic [XW-1:0] X4   = XW'(4);
    localparam logic [XW-1:0] X8   = XW'(8);
    localparam logic [XW-1:0] X12  = XW'(12);
    localparam logic [DW-1:0] TAG_PROLOGUE = DW'(9);
    localparam logic [DW-1:0] TAG_EPILOGUE = DW'(1);
    localparam logic [DW-1:0] ROVER_START  = DW'(8);
    localparam logic [BW-1:0] BRK_START    = BW'(16);
    localparam logic [GZW-1:0] INIT_GROW   = GZW'(4096);

    t_state           r_state, n_state;
    t_ctx             r_ctx, n_ctx;
    logic [WA-1:0]    r_clr, n_clr;
    logic [BW-1:0]    r_brk, n_brk;
    logic [DW-1:0]    r_rover, n_rover;
    logic [XW-1:0]    r_b, n_b;
    logic [AZW-1:0]   r_asize, n_asize;
    logic [GZW-1:0]   r_gsize, n_gsize;
    logic [DW-1:0]    r_bp, n_bp;
    logic [DW-1:0]    r_prv, n_prv;
    logic [DW-1:0]    r_nxt, n_nxt;
    logic [DW-1:0]    r_t, n_t;
    logic [DW-1:0]    r_s, n_s;
    logic [DW-1:0]    r_psz, n_psz;
    logic [DW-1:0]    r_snew, n_snew;
    logic             r_pa, n_pa;
    t_result          r_res, n_res;

    logic [DW-1:0]    w_rsz;
    logic             w_rok;
    logic             w_split;
    logic [DW-1:0]    w_asz;
    logic [SUMW-1:0]  w_grow_sum;
    logic             w_grow_fail;
    logic [AZW-1:0]   w_req_asize;
    logic [AZW-1:0]   w_ext;
    logic [GZW-1:0]   w_req_gsize;

    // Decode the word just read and the size arithmetic
    assign w_rsz       = {i_mem_rdata[DW-1:3], 3'b000};
    assign w_rok       = i_mem_rdata[0];
    assign w_split     = (r_t >= DW'(16));
    assign w_asz       = DW'(r_asize);
    assign w_grow_sum  = SUMW'(r_brk) + SUMW'(r_gsize);
    assign w_grow_fail = (w_grow_sum > SUMW'(HEAP_BYTES));
    assign w_req_asize = (i_req <= REQW'(8)) ? AZW'(16)
                       : ((AZW'(i_req) + AZW'(15)) & ~AZW'(7));
    assign w_ext       = (w_req_asize > AZW'(i_chunk)) ? w_req_asize : AZW'(i_chunk);
    assign w_req_gsize = (GZW'(w_ext) + GZW'(4)) & ~GZW'(7);

    // Drive the shared adder for the current step
    always_comb begin
        o_alu_op = '0;
        case (r_state)
            S_I0:  o_alu_op.a = X4;
            S_I1:  o_alu_op.a = X8;
            S_I2:  o_alu_op.a = X12;
            S_SC0: begin o_alu_op.a = r_b; o_alu_op.b = X4; o_alu_op.sub = 1'b1; end
            S_SC1: begin o_alu_op.a = r_b; o_alu_op.b = XW'(w_rsz); end
            S_G0: begin
                o_alu_op.a = XW'(r_brk); o_alu_op.b = X4; o_alu_op.sub = 1'b1;
            end
            S_G1: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = XW'(r_gsize); o_alu_op.k = K_M8;
            end
            S_G2: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = XW'(r_gsize); o_alu_op.k = K_M4;
            end
            S_F0, S_F1, S_M5, S_MA0, S_MC1, S_P0, S_P2: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = X4; o_alu_op.sub = 1'b1;
            end
            S_F2, S_MB0, S_PN: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = XW'(r_s); o_alu_op.k = K_M8;
            end
            S_M0, S_MX0, S_MY0: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = X8; o_alu_op.sub = 1'b1;
            end
            S_M1, S_MY1: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = XW'(w_rsz); o_alu_op.sub = 1'b1;
            end
            S_M2, S_MC0: begin
                o_alu_op.a = XW'(r_prv); o_alu_op.b = X4; o_alu_op.sub = 1'b1;
            end
            S_M3: begin
                o_alu_op.a = XW'(r_prv); o_alu_op.b = XW'(w_rsz); o_alu_op.k = K_M8;
            end
            S_M4:  o_alu_op.a = XW'(r_t);
            S_M6, S_MC2: begin o_alu_op.a = XW'(r_bp); o_alu_op.b = XW'(w_rsz); end
            S_M7, S_MC3: begin
                o_alu_op.a = XW'(r_nxt); o_alu_op.b = X4; o_alu_op.sub = 1'b1;
            end
            S_M8: begin
                o_alu_op.a = XW'(r_s);
                o_alu_op.b = w_rok ? '0 : XW'(w_rsz);
                o_alu_op.k = r_pa ? '0 : XW'(r_psz);
            end
            S_MA1: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = XW'(r_snew); o_alu_op.k = K_M8;
            end
            S_MX1: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = XW'(w_rsz);
                o_alu_op.sub = 1'b1; o_alu_op.k = K_M4;
            end
            S_MC4: begin
                o_alu_op.a = XW'(r_nxt); o_alu_op.b = XW'(w_rsz); o_alu_op.k = K_M8;
            end
            S_P1: begin
                o_alu_op.a = XW'(w_rsz); o_alu_op.b = XW'(w_asz); o_alu_op.sub = 1'b1;
            end
            S_P3: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = XW'(w_asz); o_alu_op.k = K_M8;
            end
            S_P4: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = XW'(w_asz); o_alu_op.k = K_M4;
            end
            S_P5: begin
                o_alu_op.a = XW'(r_bp); o_alu_op.b = XW'(r_t);
                o_alu_op.k = XW'(w_asz) + K_M8;
            end
            default: o_alu_op = '0;
        endcase
    end

    // Form the memory access of the current step
    always_comb begin
        o_mem_req.we    = 1'b0;
        o_mem_req.addr  = (r_state == S_CLR) ? r_clr : i_alu_y[WA+1:2];
        o_mem_req.wdata = '0;
        case (r_state)
            S_CLR: o_mem_req.we = 1'b1;
            S_I0, S_I1: begin o_mem_req.we = 1'b1; o_mem_req.wdata = TAG_PROLOGUE; end
            S_I2, S_G2: begin o_mem_req.we = 1'b1; o_mem_req.wdata = TAG_EPILOGUE; end
            S_G0: begin o_mem_req.we = !w_grow_fail; o_mem_req.wdata = DW'(r_gsize); end
            S_G1: begin o_mem_req.we = 1'b1; o_mem_req.wdata = DW'(r_gsize); end
            S_F1: begin o_mem_req.we = 1'b1; o_mem_req.wdata = w_rsz; end
            S_F2: begin o_mem_req.we = 1'b1; o_mem_req.wdata = r_s; end
            S_MA0, S_MA1, S_MB0, S_MX1, S_MC0, S_MC4: begin
                o_mem_req.we = 1'b1; o_mem_req.wdata = r_snew;
            end
            S_P2: begin
                o_mem_req.we    = 1'b1;
                o_mem_req.wdata = w_split ? (w_asz | DW'(1)) : (r_s | DW'(1));
            end
            S_P3: begin o_mem_req.we = 1'b1; o_mem_req.wdata = w_asz | DW'(1); end
            S_P4, S_P5: begin o_mem_req.we = 1'b1; o_mem_req.wdata = r_t; end
            S_PN: begin o_mem_req.we = 1'b1; o_mem_req.wdata = r_s | DW'(1); end
            default: o_mem_req.we = 1'b0;
        endcase
    end

    // Advance the sequencer
    always_comb begin
        n_state = r_state;
        n_ctx   = r_ctx;
        n_clr   = r_clr;
        n_brk   = r_brk;
        n_rover = r_rover;
        n_b     = r_b;
        n_asize = r_asize;
        n_gsize = r_gsize;
        n_bp    = r_bp;
        n_prv   = r_prv;
        n_nxt   = r_nxt;
        n_t     = r_t;
        n_s     = r_s;
        n_psz   = r_psz;
        n_snew  = r_snew;
        n_pa    = r_pa;
        n_res   = r_res;
        case (r_state)
            S_CLR: begin
                n_clr = r_clr + WA'(1);
                if (r_clr == '1) begin
                    n_state = S_I0;
                end
            end
            S_I0: n_state = S_I1;
            S_I1: n_state = S_I2;
            S_I2: begin
                n_brk   = BRK_START;
                n_gsize = INIT_GROW;
                n_ctx   = CTX_INIT;
                n_state = S_G0;
            end
            S_IDLE: begin
                if (i_in_valid) begin
                    if (i_mode == MODE_ALLOC) begin
                        n_asize = w_req_asize;
                        n_gsize = w_req_gsize;
                        n_b     = XW'(r_rover);
                        n_ctx   = CTX_ALLOC;
                        n_state = S_SC0;
                    end else if (i_off == '0) begin
                        n_res   = '{offset: '0, status: ST_NULL};
                        n_state = S_DONE;
                    end else begin
                        n_bp    = DW'(i_off);
                        n_ctx   = CTX_FREE;
                        n_state = S_F0;
                    end
                end
            end
            S_SC0: n_state = (r_b > XW'(r_brk)) ? S_G0 : S_SC1;
            S_SC1: begin
                if (w_rsz == '0) begin
                    n_state = S_G0;
                end else if (!w_rok && (w_asz <= w_rsz)) begin
                    n_bp    = r_b[DW-1:0];
                    n_state = S_P0;
                end else begin
                    n_b     = i_alu_y;
                    n_state = S_SC0;
                end
            end
            S_G0: begin
                if (w_grow_fail) begin
                    n_res   = '{offset: '0, status: ST_OOM};
                    n_state = S_DONE;
                end else begin
                    n_bp    = DW'(r_brk);
                    n_brk   = w_grow_sum[BW-1:0];
                    n_state = S_G1;
                end
            end
            S_G1: n_state = S_G2;
            S_G2: n_state = S_M0;
            S_F0: n_state = S_F1;
            S_F1: begin n_s = w_rsz; n_state = S_F2; end
            S_F2: n_state = S_M0;
            S_M0: n_state = S_M1;
            S_M1: begin n_prv = i_alu_y[DW-1:0]; n_state = S_M2; end
            S_M2: n_state = S_M3;
            S_M3: begin n_psz = w_rsz; n_t = i_alu_y[DW-1:0]; n_state = S_M4; end
            S_M4: n_state = S_M5;
            S_M5: begin n_pa = w_rok; n_state = S_M6; end
            S_M6: begin n_s = w_rsz; n_nxt = i_alu_y[DW-1:0]; n_state = S_M7; end
            S_M7: n_state = S_M8;
            S_M8: begin
                n_snew = i_alu_y[DW-1:0];
                if (r_pa && w_rok) begin
                    n_state = S_MEND;
                end else if (r_pa) begin
                    n_state = S_MA0;
                end else if (w_rok) begin
                    n_state = S_MB0;
                end else begin
                    n_state = S_MC0;
                end
            end
            S_MA0: n_state = S_MA1;
            S_MA1: n_state = S_MEND;
            S_MB0: n_state = S_MX0;
            S_MX0: n_state = S_MX1;
            S_MX1: n_state = S_MY0;
            S_MC0: n_state = S_MC1;
            S_MC1: n_state = S_MC2;
            S_MC2: begin n_nxt = i_alu_y[DW-1:0]; n_state = S_MC3; end
            S_MC3: n_state = S_MC4;
            S_MC4: n_state = S_MY0;
            S_MY0: n_state = S_MY1;
            S_MY1: begin n_bp = i_alu_y[DW-1:0]; n_state = S_MEND; end
            S_MEND: begin
                case (r_ctx)
                    CTX_INIT: begin
                        n_rover = ROVER_START;
                        n_state = S_IDLE;
                    end
                    CTX_ALLOC: n_state = S_P0;
                    default: begin
                        n_rover = r_bp;
                        n_res   = '{offset: '0, status: ST_DONE};
                        n_state = S_DONE;
                    end
                endcase
            end
            S_P0: n_state = S_P1;
            S_P1: begin n_s = w_rsz; n_t = i_alu_y[DW-1:0]; n_state = S_P2; end
            S_P2: n_state = w_split ? S_P3 : S_PN;
            S_P3: n_state = S_P4;
            S_P4: n_state = S_P5;
            S_P5, S_PN: begin
                n_res   = '{offset: r_bp[OFFW-1:0], status: ST_DONE};
                n_state = S_DONE;
            end
            S_DONE: begin
                if (i_res_ready) begin
                    n_state = S_IDLE;
                end
            end
            default: n_state = S_CLR;
        endcase
    end

    // Hold control state under reset, payload free-running
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_CLR;
            r_ctx   <= CTX_INIT;
            r_clr   <= '0;
            r_brk   <= '0;
            r_rover <= '0;
        end else begin
            r_state <= n_state;
            r_ctx   <= n_ctx;
            r_clr   <= n_clr;
            r_brk   <= n_brk;
            r_rover <= n_rover;
        end
        r_b     <= n_b;
        r_asize <= n_asize;
        r_gsize <= n_gsize;
        r_bp    <= n_bp;
        r_prv   <= n_prv;
        r_nxt   <= n_nxt;
        r_t     <= n_t;
        r_s     <= n_s;
        r_psz   <= n_psz;
        r_snew  <= n_snew;
        r_pa    <= n_pa;
        r_res   <= n_res;
    end

    assign o_in_ready  = (r_state == S_IDLE);
    assign o_res_valid = (r_state == S_DONE);
    assign o_res       = r_res;

    `HLA_ASSERT_IMP(a_idle_no_write, i_clk, i_rst_n, r_state == S_IDLE, !o_mem_req.we)
    `HLA_ASSERT_NEXT(a_accept_leaves_idle, i_clk, i_rst_n, (r_state == S_IDLE) && i_in_valid, r_state != S_IDLE)
    `HLA_ASSERT_IMP(a_break_in_heap, i_clk, i_rst_n, 1'b1, r_brk <= BW'(HEAP_BYTES))

endmodule

FILE: rtl/core/implicit_list_heap_allocator_core.sv
// Top level of the boundary-tag heap allocator
//
// Slave stream takes one request per transfer: tuser carries the mode
// (allocate or free), tdata the request size and the block offset to free.
// Master stream returns one result per request: tdata the payload offset of
// the allocated block, tuser the status (done, out of memory, null free).
// Configuration: i_cfg_we writes i_cfg_wdata into the growth step register.
// After reset the block clears the whole heap memory, one word a cycle, then
// lays down prologue, epilogue and a first free chunk; s_axis_tready stays
// low throughout. One request at a time. A null free is answered without
// touching the heap; a free merges the block with any free neighbour. An
// allocate walks the blocks first-fit from the rover, then places the block,
// split when the remainder allows, and passes the result on. A miss ends the
// walk; growth then adds a new chunk and merges it, or reports out of memory.
// The walk over block headers through the single memory port dominates the
// time of an allocate. A result sits in an output register; the next request
// is taken while it waits. If the receiver stalls, the following result holds
// in the sequencer and no further request is taken until it moves on.
module implicit_list_heap_allocator_core import hla_pkg::*; (
    input  logic            i_clk,
    input  logic            i_rst_n,
    input  logic            i_cfg_we,
    input  logic [CHW-1:0]  i_cfg_wdata,
    input  logic            s_axis_tvalid,
    output logic            s_axis_tready,
    input  logic [47:0]     s_axis_tdata,  // [20:0] request_bytes, [40:21] block_offset
    input  logic [0:0]      s_axis_tuser,  // [0] mode
    output logic            m_axis_tvalid,
    input  logic            m_axis_tready,
    output logic [23:0]     m_axis_tdata,  // [19:0] result_offset
    output logic [1:0]      m_axis_tuser   // [1:0] status
);

    logic [CHW-1:0] r_chunk;
    logic           r_out_valid;
    t_result        r_out;

    logic           w_res_valid;
    logic           w_res_ready;
    t_result        w_res;
    t_alu_op        w_alu_op;
    logic [XW-1:0]  w_alu_y;
    t_mem_req       w_mem_req;
    logic [DW-1:0]  w_mem_rdata;

    // Hold the growth step register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_chunk <= CHUNK_RESET;
        end else if (i_cfg_we) begin
            r_chunk <= i_cfg_wdata;
        end
    end

    // Output register between the sequencer and the master stream
    assign w_res_ready = !r_out_valid || m_axis_tready;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_out_valid <= 1'b0;
        end else if (w_res_valid && w_res_ready) begin
            r_out_valid <= 1'b1;
        end else if (m_axis_tready) begin
            r_out_valid <= 1'b0;
        end
        if (w_res_valid && w_res_ready) begin
            r_out <= w_res;
        end
    end

    assign m_axis_tvalid = r_out_valid;
    assign m_axis_tdata  = {4'b0000, r_out.offset};
    assign m_axis_tuser  = r_out.status;

    hla_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (s_axis_tvalid),
        .o_in_ready  (s_axis_tready),
        .i_mode      (s_axis_tuser[0]),
        .i_req       (s_axis_tdata[20:0]),
        .i_off       (s_axis_tdata[40:21]),
        .i_chunk     (r_chunk),
        .o_res_valid (w_res_valid),
        .i_res_ready (w_res_ready),
        .o_res       (w_res),
        .o_alu_op    (w_alu_op),
        .i_alu_y     (w_alu_y),
        .o_mem_req   (w_mem_req),
        .i_mem_rdata (w_mem_rdata)
    );

    hla_alu u_alu (
        .i_op (w_alu_op),
        .o_y  (w_alu_y)
    );

    hla_ram u_ram (
        .i_clk   (i_clk),
        .i_req   (w_mem_req),
        .o_rdata (w_mem_rdata)
    );

endmodule

FILE: dv/tb_implicit_list_heap_allocator_core.sv
// Self-checking testbench of the boundary-tag heap allocator core
`timescale 1ns / 100ps

module tb_implicit_list_heap_allocator_core import hla_pkg::*; ();

    localparam int unsigned HW       = 262144;
    localparam int unsigned IDLE_MAX = 2000000;

    logic            i_clk;
    logic            i_rst_n;
    logic            i_cfg_we;
    logic [CHW-1:0]  i_cfg_wdata;
    logic            s_axis_tvalid;
    logic            s_axis_tready;
    logic [47:0]     s_axis_tdata;  // [20:0] request_bytes, [40:21] block_offset
    logic [0:0]      s_axis_tuser;  // [0] mode
    logic            m_axis_tvalid;
    logic            m_axis_tready;
    logic [23:0]     m_axis_tdata;  // [19:0] result_offset
    logic [1:0]      m_axis_tuser;  // [1:0] status

    implicit_list_heap_allocator_core u_top (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cfg_we      (i_cfg_we),
        .i_cfg_wdata   (i_cfg_wdata),
        .s_axis_tvalid (s_axis_tvalid),
        .s_axis_tready (s_axis_tready),
        .s_axis_tdata  (s_axis_tdata),
        .s_axis_tuser  (s_axis_tuser),
        .m_axis_tvalid (m_axis_tvalid),
        .m_axis_tready (m_axis_tready),
        .m_axis_tdata  (m_axis_tdata),
        .m_axis_tuser  (m_axis_tuser)
    );

    // Mirror of heap memory and allocator registers
    bit [31:0]   heap_mem [HW];
    bit [31:0]   brk;
    bit [31:0]   rover;
    bit [31:0]   chunk;
    t_result     alloc_results_q [$];
    bit [19:0]   live_blocks [$];
    int          mismatches;
    int          idle_cycles;
    bit          no_gaps;

    // Clock
    initial i_clk = 1'b0;
    always #10 i_clk = ~i_clk;

    function automatic bit [31:0] hrd(bit [31:0] a);
        return heap_mem[a[19:2]];
    endfunction

    function automatic void hwr(bit [31:0] a, bit [31:0] v);
        heap_mem[a[19:2]] = v;
    endfunction

    function automatic bit [31:0] hsz(bit [31:0] bp);
        return hrd(bp - 4) & ~32'd7;
    endfunction

    function automatic bit [31:0] hal(bit [31:0] bp);
        return hrd(bp - 4) & 32'd1;
    endfunction

    function automatic bit [31:0] hft(bit [31:0] bp);
        return bp + hsz(bp) - 8;
    endfunction

    function automatic bit [31:0] hnx(bit [31:0] bp);
        return bp + hsz(bp);
    endfunction

    function automatic bit [31:0] hpv(bit [31:0] bp);
        return bp - (hrd(bp - 8) & ~32'd7);
    endfunction

    // Coalesce a free block with its neighbours, return the merged block
    function automatic bit [31:0] coalesce(bit [31:0] bp);
        bit [31:0] pa;
        bit [31:0] na;
        bit [31:0] s;
        pa = hrd(hft(hpv(bp))) & 32'd1;
        na = hal(hnx(bp));
        s  = hsz(bp);
        if (pa != 0 && na != 0) return bp;
        if (pa != 0) begin
            s += hsz(hnx(bp));
            hwr(bp - 4, s);
            hwr(hft(bp), s);
        end else if (na != 0) begin
            s += hsz(hpv(bp));
            hwr(hft(bp), s);
            hwr(hpv(bp) - 4, s);
            bp = hpv(bp);
        end else begin
            s += hsz(hnx(bp)) + hsz(hpv(bp));
            hwr(hpv(bp) - 4, s);
            hwr(hft(hnx(bp)), s);
            bp = hpv(bp);
        end
        return bp;
    endfunction

    // Extend the break, merge with a free tail
    function automatic bit grow_break(longint unsigned bytes, output bit [31:0] bp);
        longint unsigned words;
        longint unsigned sz;
        words = bytes / 4;
        sz = (words[0] ? words + 1 : words) * 4;
        bp = 0;
        if (longint'(brk) + sz > longint'(HEAP_BYTES)) return 1'b0;
        bp  = brk;
        brk = brk + sz[31:0];
        hwr(bp - 4, sz[31:0]);
        hwr(hft(bp), sz[31:0]);
        hwr(hnx(bp) - 4, 32'd1);
        bp = coalesce(bp);
        return 1'b1;
    endfunction

    function automatic bit first_fit(bit [31:0] asize, output bit [31:0] bp);
        longint unsigned b;
        bit [31:0] s;
        b  = rover;
        bp = 0;
        while (b <= longint'(brk)) begin
            s = hsz(b[31:0]);
            if (s == 0) break;
            if (hal(b[31:0]) == 0 && asize <= s) begin
                bp = b[31:0];
                return 1'b1;
            end
            b += s;
        end
        return 1'b0;
    endfunction

    function automatic void place(bit [31:0] bp, bit [31:0] asize);
        bit [31:0] s;
        s = hsz(bp);
        if (s - asize >= 16) begin
            hwr(bp - 4, asize | 1);
            hwr(hft(bp), asize | 1);
            bp = hnx(bp);
            hwr(bp - 4, s - asize);
            hwr(hft(bp), s - asize);
        end else begin
            hwr(bp - 4, s | 1);
            hwr(hft(bp), s | 1);
        end
    endfunction

    function automatic void heap_init();
        bit [31:0] unused;
        foreach (heap_mem[i]) heap_mem[i] = 0;
        chunk = 4096;
        hwr(4, 9);
        hwr(8, 9);
        hwr(12, 1);
        brk = 16;
        void'(grow_break(4096, unused));
        rover = 8;
    endfunction

    // Work out the result of one request and update the mirror
    function automatic t_result predict_request(logic mode, bit [20:0] req, bit [19:0] off);
        t_result   r;
        bit [31:0] asize;
        bit [31:0] bp;
        bit [31:0] s;
        longint unsigned ext;
        r.offset = '0;
        r.status = ST_DONE;
        if (mode == MODE_ALLOC) begin
            asize = (req <= 8) ? 32'd16 : 8 * ((32'(req) + 15) / 8);
            if (first_fit(asize, bp)) begin
                place(bp, asize);
                r.offset = bp[19:0];
            end else begin
                ext = (asize > chunk) ? asize : chunk;
                if (grow_break(ext, bp)) begin
                    place(bp, asize);
                    r.offset = bp[19:0];
                end else begin
                    r.status = ST_OOM;
                end
            end
        end else if (off == 0) begin
            r.status = ST_NULL;
        end else begin
            s = hsz(off);
            hwr(32'(off) - 4, s);
            hwr(hft(off), s);
            rover = coalesce(off);
        end
        return r;
    endfunction

    // Send one request, hold valid across back-to-back transfers
    task automatic send_request(logic mode, bit [20:0] req, bit [19:0] off);
        t_result r;
        int gap;
        s_axis_tvalid <= 1'b1;
        s_axis_tuser  <= mode;
        s_axis_tdata  <= {7'd0, off, req};
        @(posedge i_clk);
        while (!s_axis_tready) @(posedge i_clk);
        r = predict_request(mode, req, off);
        alloc_results_q.push_back(r);
        if (mode == MODE_ALLOC && r.status == ST_DONE) live_blocks.push_back(r.offset);
        gap = no_gaps ? 0 : $urandom_range(0, 19);
        if (gap > 0) begin
            s_axis_tvalid <= 1'b0;
            repeat (gap) @(posedge i_clk);
        end
    endtask

    task automatic alloc_bytes(bit [20:0] req);
        send_request(MODE_ALLOC, req, 20'($urandom));
    endtask

    task automatic free_block(bit [19:0] off);
        send_request(MODE_FREE, 21'($urandom), off);
    endtask

    task automatic free_live(int idx);
        bit [19:0] off;
        off = live_blocks[idx];
        live_blocks.delete(idx);
        free_block(off);
    endtask

    task automatic drain();
        s_axis_tvalid <= 1'b0;
        @(posedge i_clk);
        while (alloc_results_q.size() != 0) @(posedge i_clk);
        repeat (40) @(posedge i_clk);
    endtask

    task automatic set_chunk(bit [20:0] v);
        drain();
        i_cfg_we    <= 1'b1;
        i_cfg_wdata <= v;
        @(posedge i_clk);
        i_cfg_we    <= 1'b0;
        chunk = v;
    endtask

    // Mostly allocate and free live blocks, some null frees and oversize requests
    task automatic random_requests(int n);
        int k;
        for (int i = 0; i < n; i++) begin
            k = $urandom_range(0, 99);
            if (live_blocks.size() > 60) k = 70;
            if (k < 50) begin
                alloc_bytes(21'($urandom_range(0, 256)));
            end else if (k < 56) begin
                alloc_bytes(21'($urandom_range(257, 20000)));
            end else if (k < 58) begin
                alloc_bytes(21'($urandom_range(500000, 1048576)));
            end else if (k < 92 && live_blocks.size() != 0) begin
                free_live($urandom_range(0, live_blocks.size() - 1));
            end else begin
                free_block(20'd0);
            end
            if (i % 100 == 50) no_gaps = ~no_gaps;
        end
    endtask

    task automatic test_directed();
        bit [19:0] a [6];
        alloc_bytes(0);
        alloc_bytes(8);
        alloc_bytes(9);
        alloc_bytes(4088);
        alloc_bytes(21'd1048576);
        alloc_bytes(21'h1FFFFF);
        free_block(20'd0);
        live_blocks.delete();
        // Build a run of blocks to cover each merge case
        for (int i = 0; i < 6; i++) alloc_bytes(24);
        for (int i = 0; i < 6; i++) a[i] = live_blocks[i];
        live_blocks.delete();
        free_block(a[1]);   // both neighbours allocated
        free_block(a[0]);   // next free only
        free_block(a[3]);   // both allocated
        free_block(a[4]);   // previous free only
        free_block(a[2]);   // both neighbours free
        free_block(a[5]);   // runs into the free tail
        alloc_bytes(32);
        alloc_bytes(100);
    endtask

    task automatic test_chunk_settings();
        set_chunk(8);
        random_requests(120);
        set_chunk(21'd1048576);
        random_requests(80);
        set_chunk(24);
        random_requests(80);
        set_chunk(65536);
        random_requests(80);
        set_chunk(4096);
    endtask

    task automatic test_random_mix();
        random_requests(500);
    endtask

    // Frees of arbitrary offsets, then a few requests over the damaged heap
    task automatic test_stray_frees();
        for (int i = 0; i < 20; i++) free_block(20'($urandom));
        free_block(20'hFFFF8);
        for (int i = 0; i < 20; i++) alloc_bytes(21'($urandom_range(0, 64)));
    endtask

    // Receiver with random stalls
    initial begin
        int n;
        forever begin
            n = no_gaps ? 0 : $urandom_range(0, 19);
            if (n > 0) begin
                m_axis_tready <= 1'b0;
                repeat (n) @(posedge i_clk);
            end
            m_axis_tready <= 1'b1;
            @(posedge i_clk);
            while (!m_axis_tvalid) @(posedge i_clk);
        end
    end

    // Compare each result transfer with the oldest expectation
    always @(posedge i_clk) begin
        t_result exp_r;
        if (i_rst_n && m_axis_tvalid && m_axis_tready) begin
            if (alloc_results_q.size() == 0) begin
                mismatches++;
                if (mismatches <= 10) $display("unexpected result %h/%0d",
                    m_axis_tdata[19:0], m_axis_tuser);
            end else begin
                exp_r = alloc_results_q.pop_front();
                if (m_axis_tdata[19:0] !== exp_r.offset || m_axis_tuser !== exp_r.status) begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("mismatch: offset exp %h got %h, status exp %0d got %0d",
                            exp_r.offset, m_axis_tdata[19:0], exp_r.status, m_axis_tuser);
                end
            end
        end
    end

    // Watchdog on cycles without any transfer
    always @(posedge i_clk) begin
        if ((s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= IDLE_MAX) begin
            $display("tb_implicit_list_heap_allocator_core: done, errors");
            $finish;
        end
    end

    initial begin
        mismatches    = 0;
        idle_cycles   = 0;
        no_gaps       = 1'b0;
        i_rst_n       <= 1'b0;
        i_cfg_we      <= 1'b0;
        i_cfg_wdata   <= '0;
        s_axis_tvalid <= 1'b0;
        s_axis_tdata  <= '0;
        s_axis_tuser  <= '0;
        heap_init();
        repeat (7) @(posedge i_clk);
        i_rst_n <= 1'b1;
        test_directed();
        test_chunk_settings();
        test_random_mix();
        test_stray_frees();
        drain();
        if (mismatches == 0 && alloc_results_q.size() == 0)
            $display("tb_implicit_list_heap_allocator_core: done, clean");
        else
            $display("tb_implicit_list_heap_allocator_core: done, errors");
        $finish;
    end

endmodule

FILE: sim.f
+incdir+rtl/core
rtl/core/hla_pkg.sv
rtl/core/hla_ram.sv
rtl/core/hla_alu.sv
rtl/core/hla_ctrl.sv
rtl/core/implicit_list_heap_allocator_core.sv
dv/tb_implicit_list_heap_allocator_core.sv
